>>> hw/rtl/sm4_block_cipher_macros.svh
// Assertion macros used by the SM4 block cipher top level
`ifndef SM4_BLOCK_CIPHER_MACROS_SVH
`define SM4_BLOCK_CIPHER_MACROS_SVH

// Check that a condition implies a consequence on the same clock edge
`define SM4_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next clock edge
`define SM4_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sm4_pkg.sv
// Types, constants and round functions of the SM4 cipher
`timescale 1ns / 1ps
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundIdxW = $clog2(NumRounds);
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DefRoundsPerStage = 2;

  localparam logic [1:0] OpEncrypt = 2'd0;
  localparam logic [1:0] OpDecrypt = 2'd1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } rsp_t;

  // Round data carried down the round pipeline
  typedef struct packed {
    logic        decrypt;
    logic        zero;
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
  } round_t;

  // Status from key expansion to the top level
  typedef struct packed {
    logic busy;
    logic ready;
  } key_stat_t;

  localparam logic [31:0] Fk [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] subst(input logic [31:0] x);
    subst = {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] x);
    logic [31:0] b;
    b = subst(x);
    key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic logic [31:0] data_mix(input logic [31:0] x);
    logic [31:0] b;
    b = subst(x);
    data_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // CK word: byte j from the top is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RoundIdxW-1:0] i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
               8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
  endfunction

endpackage

>>> hw/rtl/sm4_key_expand.sv
// Iterative key schedule: one round key per cycle into a register file
`timescale 1ns / 1ps
module sm4_key_expand
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  output key_stat_t   stat,
  output logic [31:0] round_keys [NumRounds]
);

  logic [31:0]          k [4];
  logic [RoundIdxW-1:0] idx;
  logic                 busy;
  logic                 ready;
  logic [31:0]          nk;

  assign nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck_word(idx));
  assign stat = '{busy: busy, ready: ready};

  // Sequence the expansion, restart on every key change
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      ready <= 1'b0;
      idx   <= '0;
      k[0]  <= Fk[0];
      k[1]  <= Fk[1];
      k[2]  <= Fk[2];
      k[3]  <= Fk[3];
    end else if (start) begin
      busy  <= 1'b1;
      ready <= 1'b0;
      idx   <= '0;
      k[0]  <= key_high[63:32] ^ Fk[0];
      k[1]  <= key_high[31:0] ^ Fk[1];
      k[2]  <= key_low[63:32] ^ Fk[2];
      k[3]  <= key_low[31:0] ^ Fk[3];
    end else if (busy) begin
      k[0] <= k[1];
      k[1] <= k[2];
      k[2] <= k[3];
      k[3] <= nk;
      idx  <= idx + 1'b1;
      if (idx == RoundIdxW'(NumRounds - 1)) begin
        busy  <= 1'b0;
        ready <= 1'b1;
      end
    end
  end

  // Store each round key at its slot
  always_ff @(posedge clk) begin
    if (busy && !start) begin
      round_keys[idx] <= nk;
    end
  end

endmodule

>>> hw/rtl/sm4_round_stage.sv
// One pipeline stage holding RoundsPerStage cipher rounds and its valid bit
`timescale 1ns / 1ps
module sm4_round_stage
  import sm4_pkg::*;
#(
  parameter int unsigned RoundsPerStage = DefRoundsPerStage,
  parameter int unsigned FirstRound = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  round_t      in_data,
  input  logic [31:0] round_keys [NumRounds],
  output logic        out_valid,
  output round_t      out_data
);

  round_t data_next;

  // Run this stage's rounds, keys picked by direction
  always_comb begin
    logic [31:0] rk;
    logic [31:0] nx;
    data_next = in_data;
    for (int r = 0; r < RoundsPerStage; r++) begin
      rk = in_data.decrypt ? round_keys[RoundIdxW'(NumRounds - 1 - (FirstRound + r))]
                           : round_keys[RoundIdxW'(FirstRound + r)];
      nx = data_next.x0 ^ data_mix(data_next.x1 ^ data_next.x2 ^ data_next.x3 ^ rk);
      data_next.x0 = data_next.x1;
      data_next.x1 = data_next.x2;
      data_next.x2 = data_next.x3;
      data_next.x3 = nx;
    end
  end

  // Advance valid with the data when the pipe moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hw/rtl/sm4_block_cipher.sv
// Top level of the pipelined SM4 block cipher
`timescale 1ns / 1ps
// SM4 cipher with a 16-stage round pipeline (two rounds per stage) plus an
// input and an output register: one request enters per cycle while the
// output is not stalled and no key schedule runs. A key write (or reset)
// starts the key schedule, one round key per cycle; requests are held off
// while it runs. Opcode 0 encrypts, 1 decrypts, 2 and 3 give an all-zero
// result. The whole pipeline freezes while the output stalls.
module sm4_block_cipher
  import sm4_pkg::*;
#(
  parameter int unsigned RoundsPerStage = DefRoundsPerStage
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  req_t                in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsp_t                out_data
);
`include "sm4_block_cipher_macros.svh"

  localparam int unsigned NumStages = NumRounds / RoundsPerStage;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [31:0] round_keys [NumRounds];
  key_stat_t   key_stat;
  logic        advance;
  logic        in_fire;
  logic        s0_valid;
  round_t      s0_data;
  logic        pipe_valid [NumStages+1];
  round_t      pipe_data [NumStages+1];

  // Hold the key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLow:  key_low  <= cfg_data;
        default:    ;
      endcase
    end
  end

  sm4_key_expand u_key (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_write),
    .key_high   (cfg_index == RegKeyHigh ? cfg_data : key_high),
    .key_low    (cfg_index == RegKeyLow ? cfg_data : key_low),
    .stat       (key_stat),
    .round_keys (round_keys)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance || !key_stat.ready;
  assign in_fire  = in_valid && !in_stall;

  // Capture requests into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_data.decrypt <= in_data.opcode == OpDecrypt;
      s0_data.zero    <= in_data.opcode != OpEncrypt && in_data.opcode != OpDecrypt;
      s0_data.x0      <= in_data.block_high[63:32];
      s0_data.x1      <= in_data.block_high[31:0];
      s0_data.x2      <= in_data.block_low[63:32];
      s0_data.x3      <= in_data.block_low[31:0];
    end
  end

  assign pipe_valid[0] = s0_valid;
  assign pipe_data[0]  = s0_data;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    sm4_round_stage #(
      .RoundsPerStage (RoundsPerStage),
      .FirstRound     (s * RoundsPerStage)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .in_valid   (pipe_valid[s]),
      .in_data    (pipe_data[s]),
      .round_keys (round_keys),
      .out_valid  (pipe_valid[s+1]),
      .out_data   (pipe_data[s+1])
    );
  end

  // Output register: reverse the final words, zero unknown modes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pipe_valid[NumStages];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pipe_data[NumStages].zero) begin
        out_data <= '0;
      end else begin
        out_data.result_high <= {pipe_data[NumStages].x3, pipe_data[NumStages].x2};
        out_data.result_low  <= {pipe_data[NumStages].x1, pipe_data[NumStages].x0};
      end
    end
  end

  `SM4_ASSERT_IMPLY(a_no_accept_busy, clk, rst, key_stat.busy, in_stall,
                    "request accepted during key expansion")
  `SM4_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(out_data), "stalled result changed")
  `SM4_ASSERT_NEXT(a_stall_freeze, clk, rst, !advance,
                   $stable(s0_valid) && $stable(pipe_valid[NumStages]),
                   "pipeline moved while output stalled")
  `SM4_ASSERT_IMPLY(a_ready_excl, clk, rst, 1'b1, !(key_stat.busy && key_stat.ready),
                    "key schedule busy and ready together")

endmodule

>>> test/tb_sm4_block_cipher.sv
// Self-checking testbench for the pipelined SM4 block cipher
`timescale 1ns / 1ps
module tb_sm4_block_cipher;
  import sm4_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [1:0] OpZeroA = 2'd2;
  localparam logic [1:0] OpZeroB = 2'd3;

  localparam logic [7:0] SboxLut [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };
  localparam logic [31:0] FkWords [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  req_t                in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_data;

  // Local copy of the key and its schedule
  logic [63:0] key_hi = '0;
  logic [63:0] key_lo = '0;
  logic [31:0] sched [32];

  req_t pending_reqs [$];
  rsp_t expected_blocks [$];
  bit   burst_mode = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   n_enc = 0, n_dec = 0, n_zero = 0, n_keys = 0;
  int   cycles = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  bit   held_once = 1'b0;

  sm4_block_cipher uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SboxLut[x[31:24]], SboxLut[x[23:16]], SboxLut[x[15:8]], SboxLut[x[7:0]]};
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] ck_const(input int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) w = {w[23:0], 8'(((4 * i + j) * 7) & 255)};
    return w;
  endfunction

  // Rebuild the 32 round keys from the current key registers
  task automatic rebuild_schedule();
    logic [31:0] k [4];
    logic [31:0] t;
    k[0] = key_hi[63:32] ^ FkWords[0];
    k[1] = key_hi[31:0] ^ FkWords[1];
    k[2] = key_lo[63:32] ^ FkWords[2];
    k[3] = key_lo[31:0] ^ FkWords[3];
    for (int i = 0; i < 32; i++) begin
      t = sub_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
      t = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
      sched[i] = t;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = t;
    end
  endtask

  function automatic rsp_t cipher_block(input req_t r);
    logic [31:0] x [4];
    logic [31:0] t;
    rsp_t o;
    o = '0;
    if (r.opcode != OpEncrypt && r.opcode != OpDecrypt) return o;
    x[0] = r.block_high[63:32]; x[1] = r.block_high[31:0];
    x[2] = r.block_low[63:32];  x[3] = r.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      t = sub_word(x[1] ^ x[2] ^ x[3] ^ ((r.opcode == OpEncrypt) ? sched[i] : sched[31 - i]));
      t = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = t;
    end
    o.result_high = {x[3], x[2]};
    o.result_low = {x[1], x[0]};
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: predict on acceptance, then offer the next request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(cipher_block(in_data));
        if (in_data.opcode == OpEncrypt) n_enc++;
        else if (in_data.opcode == OpDecrypt) n_dec++;
        else n_zero++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, drive stall
  always @(posedge clk) begin
    rsp_t exp_blk;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_data.result_high !== exp_blk.result_high ||
              out_data.result_low !== exp_blk.result_low) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h_%h got %h_%h", exp_blk.result_high,
                       exp_blk.result_low, out_data.result_high, out_data.result_low);
          end
        end
      end
      // Hold off once for a long stretch so the pipeline backs up
      if (!held_once && results_seen == 120) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap = pick_gap();
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == RegKeyHigh) key_hi = val;
    else key_lo = val;
    rebuild_schedule();
    n_keys++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_blocks.size() > 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic push_req(input logic [1:0] op, input logic [63:0] hi, input logic [63:0] lo);
    req_t r;
    r.opcode = op; r.block_high = hi; r.block_low = lo;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(input int count);
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      push_req(op, {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    rebuild_schedule();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset key (all zero): field extremes and every opcode
    push_req(OpEncrypt, '0, '0);
    push_req(OpDecrypt, '0, '0);
    push_req(OpEncrypt, '1, '1);
    push_req(OpDecrypt, '1, '1);
    push_req(OpZeroA, '1, '1);
    push_req(OpZeroB, 64'h0123456789abcdef, 64'hfedcba9876543210);
    push_req(OpEncrypt, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    push_req(OpDecrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    wait_idle();

    // Standard vector key, back to back
    burst_mode = 1'b1;
    write_key(RegKeyHigh, 64'h0123456789abcdef);
    write_key(RegKeyLow, 64'hfedcba9876543210);
    push_req(OpEncrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);
    push_req(OpDecrypt, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
    push_req(OpEncrypt, '0, '1);
    push_req(OpDecrypt, '1, '0);
    push_req(OpZeroA, 64'h0123456789abcdef, '0);
    push_req(OpEncrypt, 64'h8000000000000000, 64'h0000000000000001);
    wait_idle();

    // All-ones key
    burst_mode = 1'b0;
    write_key(RegKeyHigh, '1);
    write_key(RegKeyLow, '1);
    push_req(OpEncrypt, '0, '0);
    push_req(OpDecrypt, '1, '1);
    push_req(OpZeroB, '0, '0);
    push_random(8);
    wait_idle();

    // Long random phase under the long hold-off
    write_key(RegKeyHigh, {$urandom, $urandom});
    write_key(RegKeyLow, {$urandom, $urandom});
    push_random(250);
    wait_idle();

    // Short random phases with single-register key changes
    for (int p = 0; p < 6; p++) begin
      burst_mode = (p % 3 == 0);
      if ($urandom_range(0, 1)) write_key(RegKeyHigh, {$urandom, $urandom});
      else write_key(RegKeyLow, {$urandom, $urandom});
      push_random(30);
      wait_idle();
    end

    // Back to the all-zero key
    write_key(RegKeyHigh, '0);
    write_key(RegKeyLow, '0);
    push_random(10);
    wait_idle();

    $display("covered %0d encrypt, %0d decrypt, %0d unknown-mode requests", n_enc, n_dec, n_zero);
    $display("over %0d key writes, %0d results checked, %0d mismatches",
             n_keys, results_seen, mismatches);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_key_expand.sv
hw/rtl/sm4_round_stage.sv
hw/rtl/sm4_block_cipher.sv
test/tb_sm4_block_cipher.sv
